### rtl/core/fmsyn_pkg.sv
// shared constants, tables and types of the two-operator fm synthesiser
package fmsyn_pkg;

  localparam int unsigned NUM_OPS = 18;
  localparam int unsigned NUM_CH  = 9;
  localparam int unsigned OP_W    = 5;
  localparam int unsigned CH_W    = 4;
  localparam int unsigned DIV_W   = 49;
  localparam int unsigned DSR_W   = 18;
  localparam int unsigned PROD_W  = 48;
  localparam int unsigned MUL_W   = 24;

  localparam logic [16:0] SR_RESET  = 17'd44100;
  localparam logic [15:0] BASE_FREQ = 16'd49716;
  localparam logic [23:0] RECIP255  = 24'd8421505;
  localparam logic [16:0] RECIP9    = 17'd116509;
  localparam logic [9:0]  ENV_MAX   = 10'd1023;

  // envelope phase codes
  localparam logic [2:0] EP_OFF = 3'd0;
  localparam logic [2:0] EP_ATT = 3'd1;
  localparam logic [2:0] EP_DEC = 3'd2;
  localparam logic [2:0] EP_SUS = 3'd3;
  localparam logic [2:0] EP_REL = 3'd4;

  // register address groups (address bits 7..5)
  localparam logic [2:0] GRP_MULT  = 3'd1;
  localparam logic [2:0] GRP_TL    = 3'd2;
  localparam logic [2:0] GRP_AR_DR = 3'd3;
  localparam logic [2:0] GRP_SL_RR = 3'd4;
  localparam logic [2:0] GRP_FREQ  = 3'd5;
  localparam logic [2:0] GRP_FB    = 3'd6;
  localparam logic [2:0] GRP_WAVE  = 3'd7;

  typedef logic signed [15:0] sine_tab_t [1024];

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DSR_W-1:0]   divisor;
  } div_req_t;

  function automatic logic [4:0] mult2(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd0: r = 5'd1;   4'd1: r = 5'd2;   4'd2: r = 5'd4;   4'd3: r = 5'd6;
      4'd4: r = 5'd8;   4'd5: r = 5'd10;  4'd6: r = 5'd12;  4'd7: r = 5'd14;
      4'd8: r = 5'd16;  4'd9: r = 5'd18;  4'd10: r = 5'd20; 4'd11: r = 5'd20;
      4'd12: r = 5'd24; 4'd13: r = 5'd24; 4'd14: r = 5'd30; default: r = 5'd30;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] rate_val(input logic [3:0] m);
    logic [9:0] r;
    case (m)
      4'd0: r = 10'd0;    4'd1: r = 10'd1;    4'd2: r = 10'd2;    4'd3: r = 10'd3;
      4'd4: r = 10'd5;    4'd5: r = 10'd7;    4'd6: r = 10'd10;   4'd7: r = 10'd14;
      4'd8: r = 10'd20;   4'd9: r = 10'd28;   4'd10: r = 10'd40;  4'd11: r = 10'd56;
      4'd12: r = 10'd80;  4'd13: r = 10'd112; 4'd14: r = 10'd160; default: r = 10'd1023;
    endcase
    return r;
  endfunction

  // modulator operator of a channel
  function automatic logic [OP_W-1:0] chan_mod_op(input logic [CH_W-1:0] c);
    logic [OP_W-1:0] r;
    case (c)
      4'd0: r = 5'd0;  4'd1: r = 5'd1;  4'd2: r = 5'd2;
      4'd3: r = 5'd6;  4'd4: r = 5'd7;  4'd5: r = 5'd8;
      4'd6: r = 5'd12; 4'd7: r = 5'd13; 4'd8: r = 5'd14;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // channel that owns an operator
  function automatic logic [CH_W-1:0] op_chan(input logic [OP_W-1:0] o);
    logic [CH_W-1:0] r;
    case (o)
      5'd0, 5'd3:   r = 4'd0;
      5'd1, 5'd4:   r = 4'd1;
      5'd2, 5'd5:   r = 4'd2;
      5'd6, 5'd9:   r = 4'd3;
      5'd7, 5'd10:  r = 4'd4;
      5'd8, 5'd11:  r = 4'd5;
      5'd12, 5'd15: r = 4'd6;
      5'd13, 5'd16: r = 4'd7;
      5'd14, 5'd17: r = 4'd8;
      default:      r = 4'd0;
    endcase
    return r;
  endfunction

  // slot number to operator, msb flags a used slot
  function automatic logic [OP_W:0] slot_decode(input logic [4:0] lo);
    logic [OP_W:0] r;
    if (lo < 5'd6) begin
      r = {1'b1, lo};
    end else if (lo >= 5'd8 && lo < 5'd14) begin
      r = {1'b1, lo - 5'd2};
    end else if (lo >= 5'd16 && lo < 5'd22) begin
      r = {1'b1, lo - 5'd4};
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // full sine table from the odd taylor polynomial in 28-bit fixed point
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] k, t, one, x2, a, b, c, d, p, mag;
    for (int i = 0; i < 1024; i++) begin
      k   = (i <= 512) ? 64'(i) : 64'(1024 - i);
      t   = (k * 64'd3454217652358) >> 21;
      one = 64'd1 << 28;
      x2  = (t * t) >> 28;
      a   = one - x2 / 64'd72;
      p   = (x2 * a) >> 28;
      b   = one - p / 64'd42;
      p   = (x2 * b) >> 28;
      c   = one - p / 64'd20;
      p   = (x2 * c) >> 28;
      d   = one - p / 64'd6;
      p   = (t * d) >> 28;
      mag = (p * 64'd32767) >> 28;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      tab[i] = (i <= 512) ? $signed(mag[15:0]) : -$signed(mag[15:0]);
    end
    return tab;
  endfunction

endpackage

### rtl/core/fmsyn_sine_rom.sv
// full-period sine table with registered read
module fmsyn_sine_rom
  import fmsyn_pkg::*;
(
  input  logic               clk_i,
  input  logic [9:0]         addr_i,
  output logic signed [15:0] data_o
);

  localparam sine_tab_t SINE = build_sine();

  logic signed [15:0] data_q;

  // synchronous table read
  always_ff @(posedge clk_i) begin
    data_q <= SINE[addr_i];
  end

  assign data_o = data_q;

endmodule

### rtl/core/fmsyn_div.sv
// restoring divider, one quotient bit per cycle
module fmsyn_div
  import fmsyn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam logic [5:0] CNT_LAST = 6'(DIV_W - 1);

  logic             busy_q, done_q;
  logic [5:0]       cnt_q;
  logic [DSR_W-1:0] rem_q, dsr_q;
  logic [DIV_W-1:0] quo_q;
  logic [DSR_W:0]   trial;
  logic             ge;

  // trial subtract of the next dividend bit
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dsr_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= ge ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/core/fm_synth_two_operator_9ch.sv
// Nine-channel two-operator fm synthesiser, top level with sequencer and shared multiplier.
// Register write: a frequency or multiplier write recomputes the phase steps through the
//   divider, 49 divider steps per operator, both operators for a channel write.
// Sample tick: channel by channel through the one shared multiplier; ready again once
//   the result is in the output register.
// Reset clears all operator and channel state and sets the sample rate to 44100.
module fm_synth_two_operator_9ch
  import fmsyn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [7:0]         reg_addr_i,
  input  logic [7:0]         reg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] mixed_sample_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RC_M1   = 4'd1;
  localparam logic [3:0] S_RC_M2   = 4'd2;
  localparam logic [3:0] S_RC_DIV  = 4'd3;
  localparam logic [3:0] S_RC_WAIT = 4'd4;
  localparam logic [3:0] S_T_ACC   = 4'd5;
  localparam logic [3:0] S_T_ENV   = 4'd6;
  localparam logic [3:0] S_T_MUL   = 4'd7;
  localparam logic [3:0] S_T_SCL   = 4'd8;
  localparam logic [3:0] S_T_OUT   = 4'd9;
  localparam logic [3:0] S_T_D9    = 4'd10;
  localparam logic [3:0] S_T_MIX   = 4'd11;
  localparam logic [3:0] S_T_FIN   = 4'd12;

  // operator and channel state
  logic [3:0]         op_mult_q  [NUM_OPS];
  logic [5:0]         op_tl_q    [NUM_OPS];
  logic [7:0]         op_ardr_q  [NUM_OPS];
  logic [7:0]         op_slrr_q  [NUM_OPS];
  logic [1:0]         op_wf_q    [NUM_OPS];
  logic [2:0]         op_fb_q    [NUM_OPS];
  logic               op_con_q   [NUM_OPS];
  logic [31:0]        op_acc_q   [NUM_OPS];
  logic [31:0]        op_step_q  [NUM_OPS];
  logic [9:0]         op_env_q   [NUM_OPS];
  logic [2:0]         op_eph_q   [NUM_OPS];
  logic signed [15:0] op_last_q  [NUM_OPS];
  logic [7:0]         ch_flo_q   [NUM_CH];
  logic [4:0]         ch_fhi_q   [NUM_CH];
  logic               ch_key_q   [NUM_CH];

  logic [16:0]        sample_rate_q;
  logic [3:0]         state_q, state_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [CH_W-1:0]    chan_q, chan_d;
  logic               two_q, two_d;
  logic               car_q, car_d;
  logic               add_q, add_d;
  logic signed [17:0] mix_q, mix_d;
  logic               out_valid_q;
  logic signed [15:0] out_sample_q;

  logic [31:0]        phase_q;
  logic [1:0]         wf_q;
  logic [9:0]         att_q;
  logic               off_q;
  logic [7:0]         ms_q;
  logic               zero_q;
  logic               neg_q;
  logic signed [15:0] mod_out_q;
  logic signed [17:0] ch_out_q;
  logic [PROD_W-1:0]  prod_q;

  logic               accept;
  logic [2:0]         grp;
  logic [OP_W:0]      slot;
  logic [CH_W-1:0]    in_ch, ch_sel;
  logic               ch_ok;
  logic [OP_W-1:0]    in_m, fb_m;
  logic               old_on;

  // accept and write decode
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign grp        = reg_addr_i[7:5];
  assign slot       = slot_decode(reg_addr_i[4:0]);
  assign in_ch      = reg_addr_i[3:0];
  assign ch_ok      = in_ch < CH_W'(NUM_CH);
  assign ch_sel     = ch_ok ? in_ch : '0;
  assign in_m       = chan_mod_op(ch_sel);
  assign fb_m       = chan_mod_op(reg_addr_i[3:0]);
  assign old_on     = ch_key_q[ch_sel];

  // frequency fields of the channel that owns the current operator
  logic [CH_W-1:0] rc_ch;
  logic [9:0]      fnum;
  logic [2:0]      blk;
  assign rc_ch = op_chan(op_q);
  assign fnum  = {ch_fhi_q[rc_ch][1:0], ch_flo_q[rc_ch]};
  assign blk   = ch_fhi_q[rc_ch][4:2];

  // envelope step of the current operator
  logic [3:0]  ar, dr, sl, rr;
  logic [9:0]  env_cur;
  logic [2:0]  eph_cur, eph_n;
  logic [10:0] env_n, slv;
  logic [11:0] att_sum;
  logic        env_off;
  always_comb begin
    ar      = op_ardr_q[op_q][7:4];
    dr      = op_ardr_q[op_q][3:0];
    sl      = op_slrr_q[op_q][7:4];
    rr      = op_slrr_q[op_q][3:0];
    env_cur = op_env_q[op_q];
    eph_cur = op_eph_q[op_q];
    slv     = {1'b0, sl, 6'b0} + {5'b0, sl, 2'b0};
    env_n   = {1'b0, env_cur};
    eph_n   = eph_cur;
    env_off = 1'b0;
    case (eph_cur)
      EP_ATT: begin
        if (ar != 4'd0) begin
          if (env_cur <= rate_val(ar)) begin
            env_n = '0;
            eph_n = EP_DEC;
          end else begin
            env_n = {1'b0, env_cur - rate_val(ar)};
          end
        end
      end
      EP_DEC: begin
        if (dr == 4'd0 || {1'b0, env_cur} >= slv) begin
          env_n = slv;
          eph_n = EP_SUS;
        end else begin
          env_n = {1'b0, env_cur} + {1'b0, rate_val(dr)};
          if (env_n > slv) begin
            env_n = slv;
          end
        end
      end
      EP_SUS: begin
      end
      EP_REL: begin
        if (rr == 4'd0) begin
          env_n = {1'b0, ENV_MAX};
          eph_n = EP_OFF;
        end else begin
          env_n = {1'b0, env_cur} + {1'b0, rate_val(rr)};
          if (env_n >= {1'b0, ENV_MAX}) begin
            env_n = {1'b0, ENV_MAX};
            eph_n = EP_OFF;
          end
        end
      end
      default: env_off = 1'b1;
    endcase
    att_sum = {1'b0, env_n} + {2'b0, op_tl_q[op_q], 4'b0};
  end

  // phase of the current operator
  logic [31:0] acc_new, fb_term, mod_term, phase_n;
  logic [2:0]  fb;
  always_comb begin
    acc_new  = op_acc_q[op_q] + op_step_q[op_q];
    fb       = op_fb_q[op_q];
    fb_term  = (fb != 3'd0) ?
               ({{16{op_last_q[op_q][15]}}, op_last_q[op_q]} << (4'd9 - {1'b0, fb})) : '0;
    mod_term = {{16{mod_out_q[15]}}, mod_out_q} << 8;
    if (!car_q) begin
      phase_n = acc_new + fb_term;
    end else begin
      phase_n = add_q ? acc_new : acc_new + mod_term;
    end
  end

  // output scale 255 - att*255/1023
  logic [17:0] x255;
  logic [8:0]  q1023;
  logic [10:0] r1023;
  logic [7:0]  ms_n;
  always_comb begin
    x255  = {att_q, 8'b0} - {8'b0, att_q};
    r1023 = {1'b0, x255[9:0]} + {3'b0, x255[17:10]};
    q1023 = {1'b0, x255[17:10]} + ((r1023 >= 11'd1023) ? 9'd1 : 9'd0);
    ms_n  = off_q ? 8'd0 : 8'(9'd255 - q1023);
  end

  // waveform table lookup
  logic [9:0]         idx, rom_addr;
  logic               zero_n;
  logic signed [15:0] rom_data;
  assign idx      = phase_q[31:22];
  assign rom_addr = wf_q[1] ? {1'b0, idx[8:0]} : idx;
  assign zero_n   = (wf_q == 2'd1 && idx[9]) || (wf_q == 2'd3 && idx[8]);

  fmsyn_sine_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // operand forming around the shared multiplier
  logic [14:0]        wmag;
  logic signed [15:0] q255, op_val;
  logic [16:0]        ch_abs, q9;
  logic [MUL_W-1:0]   mul_a, mul_b;
  assign wmag   = rom_data[15] ? 15'(-rom_data) : rom_data[14:0];
  assign q255   = $signed(prod_q[46:31]);
  assign op_val = neg_q ? -q255 : q255;
  assign ch_abs = ch_out_q[17] ? 17'(-ch_out_q) : ch_out_q[16:0];
  assign q9     = prod_q[36:20];

  always_comb begin
    case (state_q)
      S_RC_M1: begin
        mul_a = MUL_W'(fnum);
        mul_b = MUL_W'(mult2(op_mult_q[op_q]));
      end
      S_RC_M2: begin
        mul_a = MUL_W'(prod_q[14:0]);
        mul_b = MUL_W'(BASE_FREQ);
      end
      S_T_MUL: begin
        mul_a = zero_q ? '0 : MUL_W'(wmag);
        mul_b = MUL_W'(ms_q);
      end
      S_T_SCL: begin
        mul_a = MUL_W'(prod_q[22:0]);
        mul_b = RECIP255;
      end
      S_T_D9: begin
        mul_a = MUL_W'(ch_abs);
        mul_b = MUL_W'(RECIP9);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // phase step divider
  div_req_t         div_req;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  assign div_req.start    = (state_q == S_RC_DIV) && (sample_rate_q != '0);
  assign div_req.dividend = DIV_W'(prod_q[30:0]) << ({2'b0, blk} + 5'd11);
  assign div_req.divisor  = {sample_rate_q, 1'b0};

  fmsyn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // sequencer
  logic signed [17:0] mix_term;
  assign mix_term = ch_out_q[17] ? -$signed({1'b0, q9}) : $signed({1'b0, q9});

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    chan_d  = chan_q;
    two_d   = two_q;
    car_d   = car_q;
    add_d   = add_q;
    mix_d   = mix_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i) begin
            op_d    = '0;
            chan_d  = '0;
            car_d   = 1'b0;
            mix_d   = '0;
            state_d = S_T_ACC;
          end else if (grp == GRP_MULT && slot[OP_W]) begin
            op_d    = slot[OP_W-1:0];
            two_d   = 1'b0;
            state_d = S_RC_M1;
          end else if (grp == GRP_FREQ && ch_ok) begin
            op_d    = in_m;
            two_d   = 1'b1;
            state_d = S_RC_M1;
          end
        end
      end
      S_RC_M1:  state_d = S_RC_M2;
      S_RC_M2:  state_d = S_RC_DIV;
      S_RC_DIV: begin
        if (sample_rate_q != '0) begin
          state_d = S_RC_WAIT;
        end else if (two_q) begin
          op_d    = op_q + OP_W'(3);
          two_d   = 1'b0;
          state_d = S_RC_M1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RC_WAIT: begin
        if (div_done) begin
          if (two_q) begin
            op_d    = op_q + OP_W'(3);
            two_d   = 1'b0;
            state_d = S_RC_M1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_T_ACC: begin
        if (!car_q) begin
          add_d = op_con_q[op_q];
        end
        state_d = S_T_ENV;
      end
      S_T_ENV:  state_d = S_T_MUL;
      S_T_MUL:  state_d = S_T_SCL;
      S_T_SCL:  state_d = S_T_OUT;
      S_T_OUT: begin
        if (!car_q) begin
          op_d    = op_q + OP_W'(3);
          car_d   = 1'b1;
          state_d = S_T_ACC;
        end else begin
          state_d = S_T_D9;
        end
      end
      S_T_D9:   state_d = S_T_MIX;
      S_T_MIX: begin
        mix_d = mix_q + mix_term;
        if (chan_q == CH_W'(NUM_CH - 1)) begin
          state_d = S_T_FIN;
        end else begin
          chan_d  = chan_q + CH_W'(1);
          op_d    = chan_mod_op(chan_q + CH_W'(1));
          car_d   = 1'b0;
          state_d = S_T_ACC;
        end
      end
      S_T_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= '0;
      chan_q        <= '0;
      two_q         <= 1'b0;
      car_q         <= 1'b0;
      add_q         <= 1'b0;
      mix_q         <= '0;
      sample_rate_q <= SR_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      chan_q  <= chan_d;
      two_q   <= two_d;
      car_q   <= car_d;
      add_q   <= add_d;
      mix_q   <= mix_d;
      if (cfg_we_i) begin
        sample_rate_q <= cfg_wdata_i;
      end
      // output register: loads on tick completion, clears when taken
      if (state_q == S_T_FIN && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-operator working registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_T_ACC) begin
      phase_q <= phase_n;
      wf_q    <= op_wf_q[op_q];
      att_q   <= (att_sum > 12'd1023) ? ENV_MAX : att_sum[9:0];
      off_q   <= env_off;
    end
    if (state_q == S_T_ENV) begin
      ms_q   <= ms_n;
      zero_q <= zero_n;
    end
    if (state_q == S_T_MUL) begin
      neg_q <= rom_data[15] && !zero_q;
    end
    if (state_q == S_T_OUT) begin
      if (!car_q) begin
        mod_out_q <= op_val;
      end else begin
        ch_out_q <= 18'(op_val) + (add_q ? 18'(mod_out_q) : 18'sd0);
      end
    end
    if (state_q == S_T_FIN && (!out_valid_q || out_ready_i)) begin
      if (mix_q > 18'sd32767) begin
        out_sample_q <= 16'sd32767;
      end else if (mix_q < -18'sd32767) begin
        out_sample_q <= -16'sd32767;
      end else begin
        out_sample_q <= mix_q[15:0];
      end
    end
  end

  // operator and channel state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_OPS; i++) begin
        op_mult_q[i] <= '0;
        op_tl_q[i]   <= '0;
        op_ardr_q[i] <= '0;
        op_slrr_q[i] <= '0;
        op_wf_q[i]   <= '0;
        op_fb_q[i]   <= '0;
        op_con_q[i]  <= 1'b0;
        op_acc_q[i]  <= '0;
        op_step_q[i] <= '0;
        op_env_q[i]  <= '0;
        op_eph_q[i]  <= EP_OFF;
        op_last_q[i] <= '0;
      end
      for (int j = 0; j < NUM_CH; j++) begin
        ch_flo_q[j] <= '0;
        ch_fhi_q[j] <= '0;
        ch_key_q[j] <= 1'b0;
      end
    end else begin
      // register write transaction
      if (accept && !action_i) begin
        case (grp)
          GRP_MULT: if (slot[OP_W]) op_mult_q[slot[OP_W-1:0]] <= reg_data_i[3:0];
          GRP_TL:   if (slot[OP_W]) op_tl_q[slot[OP_W-1:0]] <= reg_data_i[5:0];
          GRP_AR_DR: if (slot[OP_W]) op_ardr_q[slot[OP_W-1:0]] <= reg_data_i;
          GRP_SL_RR: if (slot[OP_W]) op_slrr_q[slot[OP_W-1:0]] <= reg_data_i;
          GRP_WAVE: if (slot[OP_W]) op_wf_q[slot[OP_W-1:0]] <= reg_data_i[1:0];
          GRP_FB: begin
            if (reg_addr_i[4:0] < 5'd9) begin
              op_fb_q[fb_m]            <= reg_data_i[3:1];
              op_con_q[fb_m]           <= reg_data_i[0];
              op_con_q[fb_m + OP_W'(3)] <= reg_data_i[0];
            end
          end
          GRP_FREQ: begin
            if (ch_ok) begin
              if (!reg_addr_i[4]) begin
                ch_flo_q[ch_sel] <= reg_data_i;
              end else begin
                ch_fhi_q[ch_sel] <= reg_data_i[4:0];
                ch_key_q[ch_sel] <= reg_data_i[5];
                // key-on edge restarts both operators
                if (reg_data_i[5] && !old_on) begin
                  op_acc_q[in_m]            <= '0;
                  op_acc_q[in_m + OP_W'(3)] <= '0;
                  op_env_q[in_m]            <= ENV_MAX;
                  op_env_q[in_m + OP_W'(3)] <= ENV_MAX;
                  op_eph_q[in_m]            <= EP_ATT;
                  op_eph_q[in_m + OP_W'(3)] <= EP_ATT;
                  op_last_q[in_m]           <= '0;
                end else if (!reg_data_i[5] && old_on) begin
                  op_eph_q[in_m]            <= EP_REL;
                  op_eph_q[in_m + OP_W'(3)] <= EP_REL;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      // phase step results
      if (state_q == S_RC_DIV && sample_rate_q == '0) begin
        op_step_q[op_q] <= '0;
      end
      if (state_q == S_RC_WAIT && div_done) begin
        op_step_q[op_q] <= div_quot[31:0];
      end
      // accumulator and envelope advance
      if (state_q == S_T_ACC) begin
        op_acc_q[op_q] <= acc_new;
        if (!env_off) begin
          op_env_q[op_q] <= env_n[9:0];
          op_eph_q[op_q] <= eph_n;
        end
      end
      // modulator output kept for feedback
      if (state_q == S_T_OUT && !car_q) begin
        op_last_q[op_q] <= op_val;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_sample_q;

endmodule

### rtl/core/fmsyn_checker.sv
// port-level checks for the fm synthesiser, bound to the top level
module fmsyn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               action_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] mixed_sample_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mixed_sample_o))
    else $error("result changed while stalled");

  // clamped sample never reaches the most negative code
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mixed_sample_o != -16'sd32768)
    else $error("sample outside clamp range");

  // a write transaction never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !action_i && !out_valid_o |=> !out_valid_o)
    else $error("result after a write");

  // a tick transaction keeps the input side busy
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i |=> !in_ready_o)
    else $error("ready straight after a tick");

endmodule

bind fm_synth_two_operator_9ch fmsyn_checker u_fmsyn_checker (.*);
